// ----- hdl/sld_pkg.sv -----
// shared types and codes for the selection list deque
package sld_pkg;

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_CHECK      = 3'd4,
    OP_READ_INDEX = 3'd5,
    OP_READ_LAST  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } state_e;

  localparam int TypeW = 8;
  localparam int IdW   = 32;
  localparam int OpW   = 3;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TypeW-1:0] typ;
  } entry_t;

  typedef struct packed {
    status_e          status;
    logic             found;
    logic [TypeW-1:0] read_type;
    logic [IdW-1:0]   read_id;
  } result_t;

endpackage

// ----- hdl/selection_list_deque.sv -----
// selection list deque: bounded ordered list of type and id pairs
//
// input channel s_axis_*: one transfer carries one operation (append, remove
// first, remove last, clear, check, read at index, read last, code 7 no-op).
// output channel m_axis_*: exactly one result transfer per input transfer,
// in order, with status, found flag, read data and the count after the op.
// one item is handled at a time; s_axis_tready is high only while idle.
// from accept, append, removes, clear and no-op pass through exec to done;
// the reads add a read state for the registered store read; a check scans the
// held entries (none on an empty list), since the scan reads the entry store through
// its single read port one entry per cycle and the compare lags each read;
// a check that hits stops early. the next item is taken once the result is
// loaded into the output register and the sequencer is back in idle.
// the result sits in an output register; if m_axis_tready stays low the
// sequencer holds its result and takes no new item until that slot frees.
// reset clears head and count, so the list starts empty; the store itself
// is not cleared and needs no clearing pass.
module selection_list_deque #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int InW = 3 + 8 + 32 + AW,
  localparam int OutW = 2 + 1 + 8 + 32 + CW,
  localparam int InBytesW = ((InW + 7) / 8) * 8,
  localparam int OutBytesW = ((OutW + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // operation, element_type, element_id, position
  input  logic [InBytesW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status, found, read_type, read_id, count
  output logic [OutBytesW-1:0] m_axis_tdata
);
  import sld_pkg::*;

  op_e                  req_op;
  entry_t               req_key;
  logic [AW-1:0]        req_pos;
  logic                 res_valid;
  logic                 res_take;
  result_t              res;
  logic [CW-1:0]        count;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  entry_t               wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  entry_t               rd_data;
  logic                 out_valid_q;
  logic [OutBytesW-1:0] out_data_q;

  assign req_op      = op_e'(s_axis_tdata[OpW-1:0]);
  assign req_key.typ = s_axis_tdata[OpW +: TypeW];
  assign req_key.id  = s_axis_tdata[OpW+TypeW +: IdW];
  assign req_pos     = s_axis_tdata[OpW+TypeW+IdW +: AW];

  // output slot is free when empty or being drained this cycle
  assign res_take = !out_valid_q || m_axis_tready;

  sld_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_op_i   (req_op),
    .req_key_i  (req_key),
    .req_pos_i  (req_pos),
    .res_valid_o(res_valid),
    .res_take_i (res_take),
    .res_o      (res),
    .count_o    (count),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  sld_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) begin
      out_data_q <= OutBytesW'({count, res.read_id, res.read_type, res.found,
                                res.status});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- hdl/sld_mem.sv -----
// entry store: one write port and one registered read port
module sld_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  sld_pkg::entry_t wr_data_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output sld_pkg::entry_t rd_data_o
);
  import sld_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/sld_ctrl.sv -----
// sequencer, head and count registers, address unit and scan compare
module sld_ctrl #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  sld_pkg::op_e     req_op_i,
  input  sld_pkg::entry_t  req_key_i,
  input  logic [AW-1:0]    req_pos_i,
  output logic             res_valid_o,
  input  logic             res_take_i,
  output sld_pkg::result_t res_o,
  output logic [CW-1:0]    count_o,
  output logic             wr_en_o,
  output logic [AW-1:0]    wr_addr_o,
  output sld_pkg::entry_t  wr_data_o,
  output logic             rd_en_o,
  output logic [AW-1:0]    rd_addr_o,
  input  sld_pkg::entry_t  rd_data_i
);
  import sld_pkg::*;

  localparam int SW = CW + 1;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  state_e        state_q, state_d;
  op_e           op_q, op_d;
  entry_t        key_q, key_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_k_q, scan_k_d;
  logic [AW-1:0] scan_slot_q, scan_slot_d;
  logic          cmp_valid_q, cmp_valid_d;
  result_t       res_q, res_d;
  logic          hit;
  logic          empty;

  // physical slot of logical position k, circular over the store
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(k);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return AW'(s);
  endfunction

  assign empty = (count_q == '0);
  assign hit   = cmp_valid_q && (rd_data_i == key_q);

  always_comb begin : next_state
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (op_q)
          OP_CHECK: state_d = ST_SCAN;
          OP_READ_INDEX: begin
            if (empty || (CW'(pos_q) >= count_q)) state_d = ST_DONE;
            else state_d = ST_READ;
          end
          OP_READ_LAST: begin
            if (empty) state_d = ST_DONE;
            else state_d = ST_READ;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_READ: state_d = ST_DONE;
      ST_SCAN: begin
        if (hit || ((scan_k_q == count_q) && !cmp_valid_q)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_take_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin : datapath
    op_d        = op_q;
    key_d       = key_q;
    pos_d       = pos_q;
    head_d      = head_q;
    count_d     = count_q;
    scan_k_d    = scan_k_q;
    scan_slot_d = scan_slot_q;
    cmp_valid_d = cmp_valid_q;
    res_d       = res_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = slot_of(head_q, count_q);
    wr_data_o   = key_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = scan_slot_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          op_d  = req_op_i;
          key_d = req_key_i;
          pos_d = req_pos_i;
          res_d = '0;
        end
      end
      ST_EXEC: begin
        case (op_q)
          OP_APPEND: begin
            if (count_q == DepthC) begin
              res_d.status = STAT_FULL;
            end else begin
              wr_en_o = 1'b1;
              count_d = count_q + OneC;
            end
          end
          OP_POP_FRONT: begin
            if (empty) begin
              res_d.status = STAT_EMPTY;
            end else begin
              count_d = count_q - OneC;
              head_d  = (count_q == OneC) ? '0 : slot_of(head_q, OneC);
            end
          end
          OP_POP_BACK: begin
            if (empty) begin
              res_d.status = STAT_EMPTY;
            end else begin
              count_d = count_q - OneC;
              if (count_q == OneC) head_d = '0;
            end
          end
          OP_CLEAR: begin
            count_d = '0;
            head_d  = '0;
          end
          OP_CHECK: begin
            scan_k_d    = '0;
            scan_slot_d = head_q;
            cmp_valid_d = 1'b0;
          end
          OP_READ_INDEX: begin
            if (empty) begin
              res_d.status = STAT_EMPTY;
            end else if (CW'(pos_q) >= count_q) begin
              res_d.status = STAT_RANGE;
            end else begin
              rd_en_o   = 1'b1;
              rd_addr_o = slot_of(head_q, CW'(pos_q));
            end
          end
          OP_READ_LAST: begin
            if (empty) begin
              res_d.status = STAT_EMPTY;
            end else begin
              rd_en_o   = 1'b1;
              rd_addr_o = slot_of(head_q, count_q - OneC);
            end
          end
          default: ;
        endcase
      end
      ST_READ: begin
        res_d.read_type = rd_data_i.typ;
        res_d.read_id   = rd_data_i.id;
      end
      ST_SCAN: begin
        // reads are issued one per cycle, compare lags the issue by the registered store read
        if (hit) begin
          res_d.found = 1'b1;
          cmp_valid_d = 1'b0;
        end else if (scan_k_q != count_q) begin
          rd_en_o     = 1'b1;
          rd_addr_o   = scan_slot_q;
          scan_k_d    = scan_k_q + OneC;
          scan_slot_d = (scan_slot_q == LastSlot) ? '0 : scan_slot_q + AW'(1);
          cmp_valid_d = 1'b1;
        end else begin
          cmp_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      cmp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      cmp_valid_q <= cmp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    pos_q       <= pos_d;
    scan_k_q    <= scan_k_d;
    scan_slot_q <= scan_slot_d;
    res_q       <= res_d;
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;
  assign count_o     = count_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above depth");

  a_head_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == '0))
    else $error("head not reset on empty list");

  a_write_append : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> ((state_q == ST_EXEC) && (op_q == OP_APPEND) && (count_q != DepthC)))
    else $error("store write outside append");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && (res_q.status == STAT_FULL)) |-> (op_q == OP_APPEND))
    else $error("full status on non-append");

  a_scan_stays : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && $past(state_q == ST_SCAN)) |-> $stable(count_q))
    else $error("count changed during scan");
`endif

endmodule
